// ===== rtl/core/arpc_pkg.sv =====
// package for the arp cache responder core: types, constants and table size
package arpc_pkg;
	localparam int TableEntries = 128;
	localparam logic [10:0] ArpMinLen = 11'd28;
	localparam logic [15:0] OpRequest16 = 16'h0001;
	localparam logic [15:0] ArpHtypeEther = 16'h0001;
	localparam logic [15:0] ArpPtypeIpv4 = 16'h0800;
	localparam logic [1:0] FrameOpNone = 2'd0;
	localparam logic [1:0] FrameOpRequest = 2'd1;
	localparam logic [1:0] FrameOpReply = 2'd2;
	localparam logic [1:0] ModeRx = 2'd0;
	localparam logic [1:0] ModeQuery = 2'd1;
	localparam logic [1:0] ModeSend = 2'd2;
	localparam logic CfgLocalIp = 1'b0;
	localparam logic CfgLocalMac = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [10:0] payload_length;
		logic [15:0] arp_opcode;
		logic [31:0] src_ip;
		logic [47:0] src_mac;
		logic [31:0] dst_ip;
		logic [31:0] query_ip;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic [47:0] resolved_mac;
		logic learn_dropped;
		logic send_frame;
		logic [47:0] frame_dest_mac;
		logic [1:0] frame_opcode;
		logic [47:0] frame_target_mac;
		logic [31:0] frame_target_ip;
	} out_item_t;

	// token passed from cell to cell along the chain
	typedef struct packed {
		logic active;
		logic learn;
		logic [31:0] ip;
		logic [47:0] mac;
		logic found;
		logic [47:0] found_mac;
		logic free_seen;
	} tok_t;

	// second pass write token: claim first free entry
	typedef struct packed {
		logic active;
		logic claim;
		logic [31:0] ip;
		logic [47:0] mac;
	} wtok_t;
endpackage

// ===== rtl/core/arpc_cell.sv =====
// one table entry cell: holds an entry and passes the scan tokens along
module arpc_cell (
	input  logic clk,
	input  logic arst_n,
	input  arpc_pkg::tok_t tok_in,
	input  arpc_pkg::wtok_t wtok_in,
	output arpc_pkg::tok_t tok_out,
	output arpc_pkg::wtok_t wtok_out
);
	logic valid_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	arpc_pkg::tok_t tok_q;
	arpc_pkg::wtok_t wtok_q;
	arpc_pkg::tok_t tok_d;
	arpc_pkg::wtok_t wtok_d;
	logic match;
	logic take;

	assign match = tok_in.active && valid_q && (ip_q == tok_in.ip) && !tok_in.found;
	assign take = wtok_in.active && wtok_in.claim && !valid_q;

	always_comb begin
		tok_d = tok_in;
		if (match) begin
			tok_d.found = 1'b1;
			tok_d.found_mac = mac_q;
		end
		if (tok_in.active && !valid_q)
			tok_d.free_seen = 1'b1;
		wtok_d = wtok_in;
		if (take)
			wtok_d.claim = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q <= '0;
			wtok_q <= '0;
		end else begin
			tok_q <= tok_d;
			wtok_q <= wtok_d;
			if (take)
				valid_q <= 1'b1;
		end
	end

	// payload writes
	always_ff @(posedge clk) begin
		if (take) begin
			ip_q <= wtok_in.ip;
			mac_q <= wtok_in.mac;
		end else if (match && tok_in.learn)
			mac_q <= tok_in.mac;
	end

	assign tok_out = tok_q;
	assign wtok_out = wtok_q;
endmodule

// ===== rtl/core/arp_cache_responder_core.sv =====
// top level of the arp cache responder: control, config and cell chain
// short packets, send requests and undefined modes are answered without entering the chain
// lookups and learns of a known sender or into a full table make one scan pass through the chain
// learns that claim a free entry add a second claim pass after the scan
// one item at a time; a new item waits until the token walk ends and the result is taken
// reset clears all entry valid bits at once, the config registers, the output valid and the control
module arp_cache_responder_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  arpc_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output arpc_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_index,
	input  logic [47:0] cfg_data
);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StScan = 2'd1;
	localparam logic [1:0] StClaim = 2'd2;
	localparam int N = arpc_pkg::TableEntries;

	logic [1:0] state_q;
	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	arpc_pkg::in_item_t item_q;
	logic reply_q;
	logic out_valid_q;
	arpc_pkg::out_item_t out_q;
	arpc_pkg::out_item_t out_d;

	arpc_pkg::tok_t tok [N+1];
	arpc_pkg::wtok_t wtok [N+1];
	arpc_pkg::tok_t tok_inj;
	arpc_pkg::wtok_t wtok_inj;

	logic accept;
	logic rx_ok;

	assign cfg_ready = 1'b1;
	// a new item only when idle and the result slot is free
	assign in_ready = (state_q == StIdle) && !out_valid_q;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign rx_ok = in_data.payload_length >= arpc_pkg::ArpMinLen;

	// chain injection
	always_comb begin
		tok_inj = '0;
		wtok_inj = '0;
		if (accept && ((in_data.mode == arpc_pkg::ModeRx && rx_ok) ||
				in_data.mode == arpc_pkg::ModeQuery)) begin
			tok_inj.active = 1'b1;
			tok_inj.learn = (in_data.mode == arpc_pkg::ModeRx);
			tok_inj.ip = (in_data.mode == arpc_pkg::ModeRx) ? in_data.src_ip
				: in_data.query_ip;
			tok_inj.mac = in_data.src_mac;
		end
		// claim pass when learning found no match and a free entry was seen
		if (state_q == StScan && tok[N].active && tok[N].learn && !tok[N].found &&
				tok[N].free_seen) begin
			wtok_inj.active = 1'b1;
			wtok_inj.claim = 1'b1;
			wtok_inj.ip = tok[N].ip;
			wtok_inj.mac = tok[N].mac;
		end
	end

	assign tok[0] = tok_inj;
	assign wtok[0] = wtok_inj;

	for (genvar g = 0; g < N; g++) begin : g_cell
		arpc_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.tok_in(tok[g]), .wtok_in(wtok[g]),
			.tok_out(tok[g+1]), .wtok_out(wtok[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			local_ip_q <= '0;
			local_mac_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					arpc_pkg::CfgLocalIp: local_ip_q <= cfg_data[31:0];
					arpc_pkg::CfgLocalMac: local_mac_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						if ((in_data.mode == arpc_pkg::ModeRx && rx_ok) ||
								in_data.mode == arpc_pkg::ModeQuery)
							state_q <= StScan;
						else
							out_valid_q <= 1'b1;
					end
				end
				StScan: begin
					// token reached the chain end
					if (tok[N].active) begin
						if (wtok_inj.active)
							state_q <= StClaim;
						else begin
							state_q <= StIdle;
							out_valid_q <= 1'b1;
						end
					end
				end
				StClaim: begin
					if (wtok[N].active) begin
						state_q <= StIdle;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// result assembly
	always_comb begin
		out_d = out_q;
		if (accept) begin
			out_d = '0;
			if (in_data.mode == arpc_pkg::ModeSend) begin
				out_d.send_frame = 1'b1;
				out_d.frame_dest_mac = '1;
				out_d.frame_opcode = arpc_pkg::FrameOpRequest;
				out_d.frame_target_ip = in_data.dst_ip;
			end
		end
		if (state_q == StScan && tok[N].active) begin
			if (item_q.mode == arpc_pkg::ModeQuery) begin
				out_d.hit = tok[N].found;
				out_d.resolved_mac = tok[N].found ? tok[N].found_mac : 48'd0;
			end else begin
				// table full: no match and no free entry seen
				out_d.learn_dropped = !tok[N].found && !tok[N].free_seen;
				if (reply_q) begin
					out_d.send_frame = 1'b1;
					out_d.frame_dest_mac = item_q.src_mac;
					out_d.frame_opcode = arpc_pkg::FrameOpReply;
					out_d.frame_target_mac = item_q.src_mac;
					out_d.frame_target_ip = item_q.src_ip;
				end
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
			reply_q <= (in_data.arp_opcode == arpc_pkg::OpRequest16) &&
				(in_data.dst_ip == local_ip_q);
		end
		out_q <= out_d;
	end
endmodule

// ===== bench/arpc_checker.sv =====
// checker for the arp cache responder: predicts each result and compares it
`timescale 1ns / 1ps
module arpc_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  arpc_pkg::in_item_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  arpc_pkg::out_item_t out_data,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_index,
	input  logic [47:0] cfg_data,
	output int errors,
	output int pending
);
	logic [31:0] my_ip;
	logic [47:0] my_mac;
	logic        tbl_valid [arpc_pkg::TableEntries];
	logic [31:0] tbl_ip [arpc_pkg::TableEntries];
	logic [47:0] tbl_mac [arpc_pkg::TableEntries];
	arpc_pkg::out_item_t expected_q [$];

	function automatic int find_ip(logic [31:0] ip);
		for (int i = 0; i < arpc_pkg::TableEntries; i++)
			if (tbl_valid[i] && tbl_ip[i] == ip)
				return i;
		return -1;
	endfunction

	// apply one item to the shadow table and return the expected result
	function automatic arpc_pkg::out_item_t arp_predict(arpc_pkg::in_item_t it);
		arpc_pkg::out_item_t r;
		int idx;
		bit stored;
		r = '0;
		if (it.mode == arpc_pkg::ModeRx) begin
			if (it.payload_length >= arpc_pkg::ArpMinLen) begin
				idx = find_ip(it.src_ip);
				if (idx >= 0) begin
					tbl_mac[idx] = it.src_mac;
				end else begin
					stored = 1'b0;
					for (int i = 0; i < arpc_pkg::TableEntries && !stored; i++)
						if (!tbl_valid[i]) begin
							tbl_valid[i] = 1'b1;
							tbl_ip[i] = it.src_ip;
							tbl_mac[i] = it.src_mac;
							stored = 1'b1;
						end
					r.learn_dropped = !stored;
				end
				if (it.arp_opcode == arpc_pkg::OpRequest16 && it.dst_ip == my_ip) begin
					r.send_frame = 1'b1;
					r.frame_dest_mac = it.src_mac;
					r.frame_opcode = arpc_pkg::FrameOpReply;
					r.frame_target_mac = it.src_mac;
					r.frame_target_ip = it.src_ip;
				end
			end
		end else if (it.mode == arpc_pkg::ModeQuery) begin
			idx = find_ip(it.query_ip);
			if (idx >= 0) begin
				r.hit = 1'b1;
				r.resolved_mac = tbl_mac[idx];
			end
		end else if (it.mode == arpc_pkg::ModeSend) begin
			r.send_frame = 1'b1;
			r.frame_dest_mac = '1;
			r.frame_opcode = arpc_pkg::FrameOpRequest;
			r.frame_target_ip = it.dst_ip;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		arpc_pkg::out_item_t e;
		if (!arst_n) begin
			my_ip = '0;
			my_mac = '0;
			errors = 0;
			expected_q.delete();
			pending = 0;
			for (int i = 0; i < arpc_pkg::TableEntries; i++) tbl_valid[i] = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == arpc_pkg::CfgLocalIp) my_ip = cfg_data[31:0];
				else my_mac = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h",
						$time, out_data);
					errors++;
				end else begin
					e = expected_q.pop_front();
					if (e != out_data) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, out_data);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(arp_predict(in_data));
			pending = expected_q.size();
		end
	end
endmodule

// ===== bench/tb_arp_cache_responder_core.sv =====
// testbench top: stimulus, configuration phases and final verdict
`timescale 1ns / 1ps
module tb_arp_cache_responder_core;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	arpc_pkg::in_item_t in_data = '0;
	logic out_valid, out_ready = 0;
	arpc_pkg::out_item_t out_data;
	logic cfg_valid = 0, cfg_ready;
	logic cfg_index = arpc_pkg::CfgLocalIp;
	logic [47:0] cfg_data = '0;
	int errors, pending;
	bit hold_off = 0;
	bit no_stall = 0;

	// ip pool: a small pool makes hits, replaces and reply matches common
	logic [31:0] ip_pool [16];
	logic [31:0] cur_ip;

	always #6 clk = ~clk;

	arp_cache_responder_core dut (.*);

	arpc_checker chk (.*);

	// receiver stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 9);
		if (hold_off) out_ready <= 0;
		else if (no_stall) out_ready <= 1;
		else out_ready <= (r < 6);
	end

	task automatic send_item(arpc_pkg::in_item_t it);
		in_valid = 1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic write_cfg(logic idx, logic [47:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// wait for every result, then the longest item latency
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (2 * arpc_pkg::TableEntries + 8) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_ip();
		return ($urandom_range(0, 3) == 0) ? $urandom() : ip_pool[$urandom_range(0, 15)];
	endfunction

	function automatic arpc_pkg::in_item_t rand_item();
		arpc_pkg::in_item_t it;
		int k;
		it.mode = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		k = $urandom_range(0, 9);
		it.payload_length = (k == 0) ? 11'($urandom_range(0, 27)) :
			(k == 1) ? 11'($urandom) : 11'd28 + 11'($urandom_range(0, 40));
		k = $urandom_range(0, 9);
		it.arp_opcode = (k < 5) ? 16'd1 : (k < 8) ? 16'd2 : 16'($urandom);
		it.src_ip = pick_ip();
		it.src_mac = 48'({$urandom(), $urandom()});
		it.dst_ip = ($urandom_range(0, 2) == 0) ? cur_ip : pick_ip();
		it.query_ip = pick_ip();
		return it;
	endfunction

	initial begin
		#2000000000;
		$display("** arp_cache_responder_core: FAILED **");
		$finish;
	end

	initial begin
		arpc_pkg::in_item_t it;
		int burst;
		for (int i = 0; i < 16; i++) ip_pool[i] = $urandom();
		cur_ip = ip_pool[0];
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		write_cfg(arpc_pkg::CfgLocalIp, {16'h0, cur_ip});
		write_cfg(arpc_pkg::CfgLocalMac, 48'h0123_4567_89ab);

		// directed: extremes, every mode, short packet, reply, undefined mode
		it = '0;
		it.mode = arpc_pkg::ModeQuery; send_item(it);
		it.mode = arpc_pkg::ModeRx; it.payload_length = 11'd27; it.arp_opcode = 16'd1;
		it.dst_ip = cur_ip; send_item(it);
		it.payload_length = 11'd28; it.src_ip = '1; it.src_mac = '1; send_item(it);
		it.mode = arpc_pkg::ModeQuery; it.query_ip = '1; send_item(it);
		it.mode = arpc_pkg::ModeRx; it.payload_length = '1; it.arp_opcode = '1;
		it.src_mac = 48'h5555_aaaa_5555; send_item(it);
		it.mode = arpc_pkg::ModeQuery; send_item(it);
		it.mode = arpc_pkg::ModeRx; it.arp_opcode = 16'd2; it.src_ip = '0; it.src_mac = '0;
		send_item(it);
		it.mode = arpc_pkg::ModeSend; it.dst_ip = '1; send_item(it);
		it.mode = arpc_pkg::ModeSend; it.dst_ip = '0; send_item(it);
		it = '1; send_item(it);
		it.mode = arpc_pkg::ModeQuery; it.query_ip = '0; send_item(it);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin
					cur_ip = '1;
					write_cfg(arpc_pkg::CfgLocalIp, 48'h0000_ffff_ffff);
					write_cfg(arpc_pkg::CfgLocalMac, '1);
				end
				2: begin
					cur_ip = '0;
					write_cfg(arpc_pkg::CfgLocalIp, '0);
					write_cfg(arpc_pkg::CfgLocalMac, '0);
				end
				default: if (phase > 2) begin
					cur_ip = ip_pool[$urandom_range(0, 15)];
					write_cfg(arpc_pkg::CfgLocalIp, {16'h0, cur_ip});
					write_cfg(arpc_pkg::CfgLocalMac, 48'({$urandom(), $urandom()}));
				end
			endcase
			no_stall = (phase == 4);
			// phase 3 fills the table with fresh senders to reach the full case
			for (int n = 0; n < 220; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < 220; b++, n++) begin
					it = rand_item();
					if (phase == 3 && n < 150) begin
						it.mode = arpc_pkg::ModeRx;
						it.payload_length = 11'd60;
						it.src_ip = $urandom();
					end
					if (n == 100) begin
						// long receiver hold-off while items keep coming
						fork
							begin
								hold_off = 1;
								repeat (1500) @(negedge clk);
								hold_off = 0;
							end
						join_none
					end
					send_item(it);
				end
				if (n == 160) drain();
				else repeat ($urandom_range(0, 8)) @(negedge clk);
			end
			drain();
		end

		if (errors == 0)
			$display("** arp_cache_responder_core: PASSED **");
		else
			$display("** arp_cache_responder_core: FAILED **");
		$finish;
	end
endmodule
